### rtl/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg: shared definitions for the matrix to quaternion converter
// Holds the default element width, the queue depth and the component codes.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int ELEM_WIDTH_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 2;

    // Which quaternion component is taken from the square root.
    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2,
        COMP_W = 2'd3
    } comp_t;

endpackage

### rtl/rmq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_front: branch selection
// Picks the Shepperd branch, forms the radicand and the three off-diagonal
// sums or differences, and hands the record to the queue.
// ----------------------------------------------------------------------------
module rmq_front
    import rmq_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
    parameter int PW         = 4 * ELEM_WIDTH + 7
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ELEM_WIDTH-1:0] elem0,
    input  logic signed [ELEM_WIDTH-1:0] elem1,
    input  logic signed [ELEM_WIDTH-1:0] elem2,
    input  logic signed [ELEM_WIDTH-1:0] elem3,
    input  logic signed [ELEM_WIDTH-1:0] elem4,
    input  logic signed [ELEM_WIDTH-1:0] elem5,
    input  logic signed [ELEM_WIDTH-1:0] elem6,
    input  logic signed [ELEM_WIDTH-1:0] elem7,
    input  logic signed [ELEM_WIDTH-1:0] elem8,
    input  logic                         full,
    output logic                         push,
    output logic [PW-1:0]                push_data
);

    localparam int W  = ELEM_WIDTH;
    localparam int RW = W + 3;
    localparam logic signed [RW-1:0] ONE = RW'(1) << (W - 2);

    typedef struct packed {
        logic                bad;
        comp_t               diag;
        logic [W:0]          r;
        logic signed [W:0]   da;
        logic signed [W:0]   db;
        logic signed [W:0]   dc;
    } item_t;

    logic signed [RW-1:0] tr;
    logic signed [RW-1:0] r;
    logic                 accept;
    item_t                item;
    item_t                item_reg;
    logic                 valid_reg;
    logic                 valid_next;

    assign tr = RW'(elem0) + RW'(elem4) + RW'(elem8);

    always_comb
    begin
        item = '0;
        if (tr > 0)
        begin
            item.diag = COMP_W;
            r         = tr + ONE;
            item.da   = (W+1)'(elem5) - (W+1)'(elem7);
            item.db   = (W+1)'(elem6) - (W+1)'(elem2);
            item.dc   = (W+1)'(elem1) - (W+1)'(elem3);
        end
        else if (elem0 > elem4 && elem0 > elem8)
        begin
            item.diag = COMP_X;
            r         = ONE + RW'(elem0) - RW'(elem4) - RW'(elem8);
            item.da   = (W+1)'(elem1) + (W+1)'(elem3);
            item.db   = (W+1)'(elem6) + (W+1)'(elem2);
            item.dc   = (W+1)'(elem5) - (W+1)'(elem7);
        end
        else if (elem4 > elem8)
        begin
            item.diag = COMP_Y;
            r         = ONE + RW'(elem4) - RW'(elem0) - RW'(elem8);
            item.da   = (W+1)'(elem1) + (W+1)'(elem3);
            item.db   = (W+1)'(elem5) + (W+1)'(elem7);
            item.dc   = (W+1)'(elem6) - (W+1)'(elem2);
        end
        else
        begin
            item.diag = COMP_Z;
            r         = ONE + RW'(elem8) - RW'(elem0) - RW'(elem4);
            item.da   = (W+1)'(elem6) + (W+1)'(elem2);
            item.db   = (W+1)'(elem5) + (W+1)'(elem7);
            item.dc   = (W+1)'(elem1) - (W+1)'(elem3);
        end
        item.bad = (r <= 0);
        item.r   = item.bad ? '0 : r[W:0];
    end

    assign busy      = valid_reg && full;
    assign push      = valid_reg && !full;
    assign accept    = start && !busy;
    assign push_data = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

endmodule

### rtl/rmq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_fifo: decoupling queue
// Small queue between branch selection and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module rmq_fifo
    import rmq_pkg::*;
#(
    parameter int DW    = 4 * ELEM_WIDTH_DEFAULT + 7,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    output logic          pop,
    output logic [DW-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign pop      = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/rmq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_back: root and divider pipeline
// A square root stage per result bit, a rounding set-up stage, three dividers
// with a stage per quotient bit, then saturation and component placement.
// ----------------------------------------------------------------------------
module rmq_back
    import rmq_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT,
    parameter int PW         = 4 * ELEM_WIDTH + 7
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [PW-1:0]                in_data,
    output logic                         done,
    output logic signed [ELEM_WIDTH-1:0] quat_x,
    output logic signed [ELEM_WIDTH-1:0] quat_y,
    output logic signed [ELEM_WIDTH-1:0] quat_z,
    output logic signed [ELEM_WIDTH-1:0] quat_w,
    output logic                         bad_input
);

    localparam int W  = ELEM_WIDTH;
    localparam int XW = 2 * W;
    localparam int CW = 2 * W + 1;
    localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic                bad;
        comp_t               diag;
        logic [W:0]          r;
        logic signed [W:0]   da;
        logic signed [W:0]   db;
        logic signed [W:0]   dc;
    } item_t;

    typedef struct packed {
        logic                bad;
        comp_t               diag;
        logic [W-2:0]        s;
        logic [CW-1:0]       den;
    } ctl_t;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [W-1:0]  q;
        logic          ovf;
        logic          neg;
    } lane_t;

    item_t          in_item;
    logic           sq_v_reg    [W];
    item_t          sq_item_reg [W];
    logic [XW-1:0]  sq_x_reg    [W];
    logic [W+1:0]   sq_rem_reg  [W];
    logic [W-1:0]   sq_root_reg [W];

    logic           su_v_reg;
    ctl_t           su_ctl_reg;
    lane_t          su_lane_reg [3];

    logic           dv_v_reg    [W];
    ctl_t           dv_ctl_reg  [W];
    lane_t          dv_lane_reg [W][3];

    logic                done_reg;
    logic                bad_reg;
    logic signed [W-1:0] quat_reg [4];

    assign in_item = item_t'(in_data);

    // Square root of r * 2^F, one root bit per stage.
    for (genvar g = 0; g < W; g++)
    begin : g_sq
        logic          v_in;
        item_t         item_in;
        logic [XW-1:0] x_in;
        logic [W+1:0]  rem_in;
        logic [W-1:0]  root_in;
        logic [W+1:0]  rem_sh;
        logic [W+1:0]  trial;

        if (g == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign item_in = in_item;
            assign x_in    = XW'(in_item.r) << (W - 2);
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign v_in    = sq_v_reg[g-1];
            assign item_in = sq_item_reg[g-1];
            assign x_in    = sq_x_reg[g-1];
            assign rem_in  = sq_rem_reg[g-1];
            assign root_in = sq_root_reg[g-1];
        end

        assign rem_sh = {rem_in[W-1:0], x_in[2*(W-1-g)+1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[g] <= 1'b0;
            end
            else
            begin
                sq_v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_item_reg[g] <= item_in;
            sq_x_reg[g]    <= x_in;
            if (rem_sh >= trial)
            begin
                sq_rem_reg[g]  <= rem_sh - trial;
                sq_root_reg[g] <= {root_in[W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg[g]  <= rem_sh;
                sq_root_reg[g] <= {root_in[W-2:0], 1'b0};
            end
        end
    end

    // Divider set-up: magnitudes, rounded numerators and the range check.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            su_v_reg <= 1'b0;
        end
        else
        begin
            su_v_reg <= sq_v_reg[W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [W-1:0]      t;
        logic [CW-1:0]     den;
        logic signed [W:0] d;
        logic [W:0]        mag;
        logic [CW-1:0]     num;
        t   = sq_root_reg[W-1];
        den = CW'({t, 1'b0});
        su_ctl_reg.bad  <= sq_item_reg[W-1].bad;
        su_ctl_reg.diag <= sq_item_reg[W-1].diag;
        su_ctl_reg.s    <= t[W-1:1];
        su_ctl_reg.den  <= den;
        for (int k = 0; k < 3; k++)
        begin
            d   = (k == 0) ? sq_item_reg[W-1].da :
                  (k == 1) ? sq_item_reg[W-1].db : sq_item_reg[W-1].dc;
            mag = d[W] ? (W+1)'(-d) : (W+1)'(d);
            num = (CW'(mag) << (W - 2)) + CW'(t);
            su_lane_reg[k].rem <= num;
            su_lane_reg[k].q   <= '0;
            su_lane_reg[k].ovf <= (num >= (den << W));
            su_lane_reg[k].neg <= d[W];
        end
    end

    // Restoring division, one quotient bit per stage on each lane.
    for (genvar g = 0; g < W; g++)
    begin : g_dv
        logic  v_in;
        ctl_t  ctl_in;
        lane_t lane_in [3];

        if (g == 0)
        begin : g_first
            assign v_in   = su_v_reg;
            assign ctl_in = su_ctl_reg;
            for (genvar k = 0; k < 3; k++)
            begin : g_l
                assign lane_in[k] = su_lane_reg[k];
            end
        end
        else
        begin : g_next
            assign v_in   = dv_v_reg[g-1];
            assign ctl_in = dv_ctl_reg[g-1];
            for (genvar k = 0; k < 3; k++)
            begin : g_l
                assign lane_in[k] = dv_lane_reg[g-1][k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[g] <= 1'b0;
            end
            else
            begin
                dv_v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            logic [CW-1:0] sub;
            sub = ctl_in.den << (W - 1 - g);
            dv_ctl_reg[g] <= ctl_in;
            for (int k = 0; k < 3; k++)
            begin
                dv_lane_reg[g][k].ovf <= lane_in[k].ovf;
                dv_lane_reg[g][k].neg <= lane_in[k].neg;
                if (lane_in[k].rem >= sub)
                begin
                    dv_lane_reg[g][k].rem <= lane_in[k].rem - sub;
                    dv_lane_reg[g][k].q   <= {lane_in[k].q[W-2:0], 1'b1};
                end
                else
                begin
                    dv_lane_reg[g][k].rem <= lane_in[k].rem;
                    dv_lane_reg[g][k].q   <= {lane_in[k].q[W-2:0], 1'b0};
                end
            end
        end
    end

    // Saturation, sign and placement of the root component.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_v_reg[W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [W-1:0] lv [3];
        ctl_t                c;
        c = dv_ctl_reg[W-1];
        for (int k = 0; k < 3; k++)
        begin
            if (dv_lane_reg[W-1][k].ovf || dv_lane_reg[W-1][k].q[W-1])
            begin
                lv[k] = dv_lane_reg[W-1][k].neg ? SAT_MIN : SAT_MAX;
            end
            else
            begin
                lv[k] = dv_lane_reg[W-1][k].neg ? -$signed(dv_lane_reg[W-1][k].q)
                                                 : $signed(dv_lane_reg[W-1][k].q);
            end
        end
        bad_reg <= c.bad;
        for (int j = 0; j < 4; j++)
        begin
            if (c.bad)
            begin
                quat_reg[j] <= '0;
            end
            else if (j < int'(c.diag))
            begin
                quat_reg[j] <= lv[(j < 3) ? j : 2];
            end
            else if (j == int'(c.diag))
            begin
                quat_reg[j] <= W'(c.s);
            end
            else
            begin
                quat_reg[j] <= lv[(j > 0) ? j - 1 : 0];
            end
        end
    end

    assign done      = done_reg;
    assign bad_input = bad_reg;
    assign quat_x    = quat_reg[COMP_X];
    assign quat_y    = quat_reg[COMP_Y];
    assign quat_z    = quat_reg[COMP_Z];
    assign quat_w    = quat_reg[COMP_W];

endmodule

### rtl/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: Shepperd conversion of a 3x3 rotation matrix
// Nine signed Q2.14 elements in, a saturated Q2.14 unit quaternion out.
// ----------------------------------------------------------------------------
// A transaction is offered by raising start with the nine elements on elem0
// to elem8; it is taken at the rising edge where start is high and busy low.
// The front stage chooses the branch (trace, or the largest diagonal element
// with ties going to the later one), forms the radicand and the off-diagonal
// terms, and writes a record into a two-entry queue.  The back pipeline then
// takes one record every cycle through a square root with one stage per root
// bit and three restoring dividers with one stage per quotient bit.
// Each result is shown for exactly one cycle with done high: quat_x, quat_y,
// quat_z, quat_w and bad_input.  A matrix whose radicand is not positive
// yields bad_input high and all four components zero.
// Throughput is one matrix per cycle; busy stays low in normal use because
// the back pipeline never stops.  A matrix passes the front register, the
// queue, the root stages, the divider set-up, the divider stages and the
// output register.  The receiver cannot stall.  Reset empties the queue and
// clears every valid flag; nothing else is cleared.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ELEM_WIDTH-1:0] elem0,
    input  logic signed [ELEM_WIDTH-1:0] elem1,
    input  logic signed [ELEM_WIDTH-1:0] elem2,
    input  logic signed [ELEM_WIDTH-1:0] elem3,
    input  logic signed [ELEM_WIDTH-1:0] elem4,
    input  logic signed [ELEM_WIDTH-1:0] elem5,
    input  logic signed [ELEM_WIDTH-1:0] elem6,
    input  logic signed [ELEM_WIDTH-1:0] elem7,
    input  logic signed [ELEM_WIDTH-1:0] elem8,
    output logic                         done,
    output logic signed [ELEM_WIDTH-1:0] quat_x,
    output logic signed [ELEM_WIDTH-1:0] quat_y,
    output logic signed [ELEM_WIDTH-1:0] quat_z,
    output logic signed [ELEM_WIDTH-1:0] quat_w,
    output logic                         bad_input
);

    // Record width: flag, branch code, radicand and three sum or difference terms.
    localparam int PW      = 4 * ELEM_WIDTH + 7;
    localparam int LATENCY = 2 * ELEM_WIDTH + 4;

    logic          q_full;
    logic          q_push;
    logic [PW-1:0] q_push_data;
    logic          q_pop;
    logic [PW-1:0] q_pop_data;

    rmq_front #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .PW         (PW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .elem0     (elem0),
        .elem1     (elem1),
        .elem2     (elem2),
        .elem3     (elem3),
        .elem4     (elem4),
        .elem5     (elem5),
        .elem6     (elem6),
        .elem7     (elem7),
        .elem8     (elem8),
        .full      (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    rmq_fifo #(
        .DW    (PW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data)
    );

    rmq_back #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .PW         (PW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_pop),
        .in_data   (q_pop_data),
        .done      (done),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .bad_input (bad_input)
    );

    // Every accepted transaction returns after a fixed number of cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after fixed latency");

    // No result appears without a matching accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a transaction");

    // A rejected matrix gives a zero quaternion.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_input) |->
            (quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0))
        else $error("non-zero output on bad input");

    // The back pipeline never stalls, so the queue never fills.
    assert property (@(posedge clk) disable iff (!rst_n) !q_full)
        else $error("queue filled up");

endmodule

### bench/rmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_checker: result predictor and comparator for the quaternion converter
// Watches accepted matrices, predicts each quaternion and compares it with
// the next result shown by the converter.
// ----------------------------------------------------------------------------
module rmq_checker
    import rmq_pkg::*;
#(
    parameter int EW = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic signed [EW-1:0] elem0,
    input  logic signed [EW-1:0] elem1,
    input  logic signed [EW-1:0] elem2,
    input  logic signed [EW-1:0] elem3,
    input  logic signed [EW-1:0] elem4,
    input  logic signed [EW-1:0] elem5,
    input  logic signed [EW-1:0] elem6,
    input  logic signed [EW-1:0] elem7,
    input  logic signed [EW-1:0] elem8,
    input  logic                 done,
    input  logic signed [EW-1:0] quat_x,
    input  logic signed [EW-1:0] quat_y,
    input  logic signed [EW-1:0] quat_z,
    input  logic signed [EW-1:0] quat_w,
    input  logic                 bad_input,
    output int                   fail_count,
    output int                   pending
);

    localparam int FB = EW - 2;

    typedef struct packed {
        logic signed [EW-1:0] x;
        logic signed [EW-1:0] y;
        logic signed [EW-1:0] z;
        logic signed [EW-1:0] w;
        logic                 bad;
    } quat_t;

    quat_t quat_queue[$];

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [EW-1:0] clamp(longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (EW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi[EW-1:0];
        if (v < lo)
            return lo[EW-1:0];
        return v[EW-1:0];
    endfunction

    // Off-diagonal term: |d| * 2^F / 2t, rounded half away from zero.
    function automatic logic signed [EW-1:0] ratio(longint d, longint unsigned t);
        longint unsigned mag;
        longint q;
        mag = (d < 0) ? -d : d;
        q = longint'(((mag << FB) + t) / (2 * t));
        return clamp(d < 0 ? -q : q);
    endfunction

    function automatic quat_t convert(longint m[9]);
        quat_t res;
        comp_t big;
        longint d[4];
        longint rad;
        longint tr;
        longint one;
        longint unsigned t;
        logic signed [EW-1:0] c[4];
        one = 64'sd1 <<< FB;
        tr = m[0] + m[4] + m[8];
        if (tr > 0)
        begin
            big = COMP_W;
            rad = tr + one;
            d = '{m[5] - m[7], m[6] - m[2], m[1] - m[3], 0};
        end
        else if (m[0] > m[4] && m[0] > m[8])
        begin
            big = COMP_X;
            rad = one + m[0] - m[4] - m[8];
            d = '{0, m[1] + m[3], m[6] + m[2], m[5] - m[7]};
        end
        else if (m[4] > m[8])
        begin
            big = COMP_Y;
            rad = one + m[4] - m[0] - m[8];
            d = '{m[1] + m[3], 0, m[5] + m[7], m[6] - m[2]};
        end
        else
        begin
            big = COMP_Z;
            rad = one + m[8] - m[0] - m[4];
            d = '{m[6] + m[2], m[5] + m[7], 0, m[1] - m[3]};
        end
        res = '0;
        if (rad <= 0)
        begin
            res.bad = 1'b1;
            return res;
        end
        t = int_root(longint'(rad) << FB);
        for (int i = 0; i < 4; i++)
        begin
            if (i == int'(big))
                c[i] = clamp(longint'(int_root(longint'(rad) << (FB - 2))));
            else
                c[i] = ratio(d[i], t);
        end
        res.x = c[0];
        res.y = c[1];
        res.z = c[2];
        res.w = c[3];
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        longint m[9];
        quat_t want;
        if (rst_n && start && !busy)
        begin
            m = '{elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7, elem8};
            quat_queue.push_back(convert(m));
        end
        if (rst_n && done)
        begin
            if (quat_queue.size() == 0)
                report("unexpected result, quat_w", quat_w, 0);
            else
            begin
                want = quat_queue.pop_front();
                if (quat_x !== want.x) report("quat_x", quat_x, want.x);
                if (quat_y !== want.y) report("quat_y", quat_y, want.y);
                if (quat_z !== want.z) report("quat_z", quat_z, want.z);
                if (quat_w !== want.w) report("quat_w", quat_w, want.w);
                if (bad_input !== want.bad) report("bad_input", bad_input, want.bad);
            end
        end
        pending = quat_queue.size();
    end

endmodule

### bench/tb_rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion: stimulus and verdict for the converter
// Offers directed and random matrices with random gaps; a checker beside the
// block predicts every quaternion and counts any mismatch.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;

    localparam int EW = ELEM_WIDTH_DEFAULT;
    localparam int ONE = 1 << (EW - 2);
    // Wait from acceptance to result; the end of the test adds a margin.
    localparam int LATENCY = 2 * EW + 4;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    logic bad_input;
    logic signed [EW-1:0] elem [9];
    logic signed [EW-1:0] quat_x, quat_y, quat_z, quat_w;
    int fail_count;
    int pending;

    rotation_matrix_to_quaternion #(.ELEM_WIDTH(EW)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .elem0(elem[0]), .elem1(elem[1]), .elem2(elem[2]), .elem3(elem[3]),
        .elem4(elem[4]), .elem5(elem[5]), .elem6(elem[6]), .elem7(elem[7]),
        .elem8(elem[8]), .done(done), .quat_x(quat_x), .quat_y(quat_y),
        .quat_z(quat_z), .quat_w(quat_w), .bad_input(bad_input)
    );

    rmq_checker #(.EW(EW)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .elem0(elem[0]), .elem1(elem[1]), .elem2(elem[2]), .elem3(elem[3]),
        .elem4(elem[4]), .elem5(elem[5]), .elem6(elem[6]), .elem7(elem[7]),
        .elem8(elem[8]), .done(done), .quat_x(quat_x), .quat_y(quat_y),
        .quat_z(quat_z), .quat_w(quat_w), .bad_input(bad_input),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Offers one matrix from the falling edge and holds it until it is taken.
    // busy only moves on a rising edge, so it is safe to look at it here.
    // start is left high so back-to-back transactions need no extra edge.
    task automatic offer(input logic signed [EW-1:0] m [9]);
        for (int i = 0; i < 9; i++)
            elem[i] <= m[i];
        start <= 1'b1;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
    endtask

    // Random gap between transactions: mostly none or short, now and then long.
    task automatic gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 45)
            n = 0;
        else if (n < 92)
            n = $urandom_range(1, 4);
        else
            n = $urandom_range(10, 60);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // A rotation about one axis by a random angle, truncated to Q2.14. The axis
    // is chosen at random too, so that every branch is reached.
    task automatic make_rotation(output logic signed [EW-1:0] m [9]);
        real a;
        real c;
        real s;
        int ax;
        logic signed [EW-1:0] cv;
        logic signed [EW-1:0] sv;
        a = ($urandom_range(0, 62831) / 10000.0);
        c = $cos(a);
        s = $sin(a);
        cv = EW'($rtoi(c*ONE));
        sv = EW'($rtoi(s*ONE));
        ax = $urandom_range(0, 2);
        m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        case (ax)
            0: m = '{ONE, 0, 0, 0, cv, sv, 0, -sv, cv};
            1: m = '{cv, 0, -sv, 0, ONE, 0, sv, 0, cv};
            default: m = '{cv, sv, 0, -sv, cv, 0, 0, 0, ONE};
        endcase
        // Small jitter so the low bits see both values too.
        for (int i = 0; i < 9; i++)
            m[i] = EW'(int'(m[i]) + int'($urandom_range(0, 6)) - 3);
    endtask

    initial
    begin
        logic signed [EW-1:0] m [9];
        int kind;
        int timer;
        rst_n = 1'b0;
        start = 1'b0;
        for (int i = 0; i < 9; i++)
            elem[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: identity, the half-turns that select each diagonal branch,
        // a tie between diagonals and field extremes.
        offer('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
        offer('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
        offer('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE});
        offer('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE});
        offer('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        offer('{-ONE, 1, 2, 3, -ONE, 5, 6, 7, -ONE});
        offer('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
        offer('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
        offer('{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767});
        offer('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768});
        offer('{-32768, 32767, 32767, -32768, -32768, 32767, -32768, 32767, 32767});
        offer('{0, 32767, -32768, -32768, -ONE, 32767, 32767, -32768, -ONE});
        offer('{-20000, 0, 0, 0, -20000, 0, 0, 0, 20000});
        offer('{-32768, 0, 0, 0, 32767, 0, 0, 0, 32767});
        offer('{-ONE, 100, -100, 100, 0, -100, 100, 100, 0});
        offer('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768});

        // Let every outstanding result arrive before carrying on.
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        for (int n = 0; n < 800; n++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                make_rotation(m);
            else
                for (int i = 0; i < 9; i++)
                    m[i] = EW'($urandom_range(0, 65535));
            offer(m);
            gap();
            if (n == 400)
            begin
                start <= 1'b0;
                do
                    @(negedge clk);
                while (pending != 0);
            end
        end
        start <= 1'b0;

        timer = 0;
        while (pending != 0 && timer < 10000)
        begin
            @(negedge clk);
            timer++;
        end
        repeat (LATENCY + 10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_fifo.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion.sv
bench/rmq_checker.sv
bench/tb_rotation_matrix_to_quaternion.sv
